### src/rwm_pkg.sv
// Widths, constants and transaction types for the running weighted mean unit.
package rwm_pkg;

    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 40;

    // |value - mean| needs one bit more than a value
    localparam int DIFF_W = VALUE_W + 1;
    // magnitude times weight, shifted through the divider
    localparam int PROD_W = DIFF_W + WEIGHT_W;
    // partial remainder of the restoring divider
    localparam int REM_W  = TOTAL_W + 1;
    localparam int CNT_W  = $clog2(PROD_W);
    // mean plus or minus a limited quotient
    localparam int SUM_W  = VALUE_W + 3;

    localparam logic [PROD_W-1:0] Q_CAP = PROD_W'(1) << (VALUE_W + 1);
    localparam logic [CNT_W-1:0]  DIV_LAST_BIT = CNT_W'(PROD_W - 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] component_value;
        logic [WEIGHT_W-1:0]       component_weight;
        logic                      last_component;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] weighted_mean;
        logic                      zero_total_weight;
    } t_out_item;

endpackage

### src/running_weighted_mean_unit.sv
// Running weighted mean: one shared restoring divider under a small sequencer.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one component per
// transaction: signed value, unsigned weight and a last mark. The output channel
// (o_out_valid / i_out_stall / o_out_data) gives one transaction per run, on the
// component marked last: the mean and a flag for a zero total weight.
// A component with a nonzero running total passes, from acceptance to the next
// acceptance, through the idle, multiply, divider (one quotient bit per divider
// cycle, magnitude times weight over the total), update and finishing states.
// A component that leaves the total at zero goes from multiply straight to
// finishing. The result appears in the output register the cycle after the
// finishing cycle of the last component.
// The output register decouples the two sides: new components are taken while a
// result waits. If a second result is ready before the first has been taken,
// the sequencer holds in its finishing cycle until the output register frees.
// Reset (synchronous, active low) clears the mean, the total and the sequencer.
module running_weighted_mean_unit
    import rwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_UPD,
        S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic signed [VALUE_W-1:0] r_mean, n_mean;
    logic [TOTAL_W-1:0]        r_total, n_total;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [WEIGHT_W-1:0]       r_weight, n_weight;
    logic                      r_last, n_last;
    logic                      r_neg, n_neg;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_data, n_out_data;

    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         mag;
    logic [PROD_W-1:0]         product;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-1:0]          rem_sub;
    logic                      rem_ge;
    logic [PROD_W-1:0]         q_cap;
    logic signed [SUM_W-1:0]   q_ext;
    logic signed [SUM_W-1:0]   mean_ext;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] mean_sat;
    logic                      out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !(r_out_valid && i_out_stall);

    // datapath
    always_comb begin
        diff    = {r_value[VALUE_W-1], r_value} - {r_mean[VALUE_W-1], r_mean};
        mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        product = {{WEIGHT_W{1'b0}}, mag} * {{DIFF_W{1'b0}}, r_weight};

        rem_sh  = {r_rem[REM_W-2:0], r_prod[PROD_W-1]};
        rem_sub = rem_sh - {1'b0, r_total};
        rem_ge  = (rem_sh >= {1'b0, r_total});

        q_cap    = (r_prod > Q_CAP) ? Q_CAP : r_prod;
        q_ext    = signed'({1'b0, q_cap[SUM_W-2:0]});
        mean_ext = SUM_W'(r_mean);
        sum      = r_neg ? (mean_ext - q_ext) : (mean_ext + q_ext);
        if (sum > SUM_MAX) begin
            mean_sat = SUM_MAX[VALUE_W-1:0];
        end else if (sum < SUM_MIN) begin
            mean_sat = SUM_MIN[VALUE_W-1:0];
        end else begin
            mean_sat = sum[VALUE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mean      = r_mean;
        n_total     = r_total;
        n_value     = r_value;
        n_weight    = r_weight;
        n_last      = r_last;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value  = i_in_data.component_value;
                    n_weight = i_in_data.component_weight;
                    n_last   = i_in_data.last_component;
                    n_total  = r_total + TOTAL_W'(i_in_data.component_weight);
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                if (r_total == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_neg   = diff[DIFF_W-1];
                    n_prod  = product;
                    n_rem   = '0;
                    n_cnt   = DIV_LAST_BIT;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // quotient bits shift in from the bottom as the dividend leaves the top
                n_rem  = rem_ge ? rem_sub : rem_sh;
                n_prod = {r_prod[PROD_W-2:0], rem_ge};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_mean  = mean_sat;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid                  = 1'b1;
                    n_out_data.weighted_mean     = r_mean;
                    n_out_data.zero_total_weight = (r_total == '0);
                    n_mean                       = '0;
                    n_total                      = '0;
                    n_state                      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mean      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mean      <= n_mean;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_value    <= n_value;
        r_weight   <= n_weight;
        r_last     <= n_last;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

endmodule

### dv/rwm_checker.sv
// Checker for the running weighted mean unit: predicts each run's mean and compares results.
`timescale 1ns / 100ps
module rwm_checker
    import rwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_means_checked,
    output int        o_empty_runs
);

    logic signed [VALUE_W-1:0] mean_acc;
    logic [TOTAL_W-1:0]        weight_total;
    t_out_item                 expected_means[$];
    t_out_item                 want;
    int                        fail_count;
    int                        means_checked;
    int                        empty_runs;

    assign o_fail_count    = fail_count;
    assign o_means_checked = means_checked;
    assign o_empty_runs    = empty_runs;

    // mean + (value - mean) * weight / total, signed, truncated toward zero, step capped, result saturated
    function automatic logic signed [VALUE_W-1:0] next_mean(
        input logic signed [VALUE_W-1:0] mean,
        input logic signed [VALUE_W-1:0] value,
        input logic [WEIGHT_W-1:0]       weight,
        input logic [TOTAL_W-1:0]        total
    );
        longint          diff;
        longint          sum;
        longint          vmax;
        longint          vmin;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned quot;
        longint unsigned quot_cap;
        diff     = longint'(mean);
        diff     = longint'(value) - diff;
        mag      = (diff < 0) ? -diff : diff;
        prod     = mag * longint'(weight);
        quot     = prod / longint'(total);
        quot_cap = 64'd1 << (VALUE_W + 1);
        if (quot > quot_cap) begin
            quot = quot_cap;
        end
        sum  = (diff < 0) ? longint'(mean) - longint'(quot) : longint'(mean) + longint'(quot);
        vmax = (longint'(1) <<< (VALUE_W - 1)) - 1;
        vmin = -vmax - 1;
        if (sum > vmax) begin
            sum = vmax;
        end
        if (sum < vmin) begin
            sum = vmin;
        end
        return sum[VALUE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mean_acc     = '0;
            weight_total = '0;
            expected_means.delete();
            fail_count    = 0;
            means_checked = 0;
            empty_runs    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_means.size() == 0) begin
                    $error("result with no run outstanding: weighted_mean %0d, zero_total_weight %0b",
                           i_out_data.weighted_mean, i_out_data.zero_total_weight);
                    fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    means_checked++;
                    if (i_out_data.weighted_mean !== want.weighted_mean) begin
                        $error("weighted_mean: expected %0d, got %0d",
                               want.weighted_mean, i_out_data.weighted_mean);
                        fail_count++;
                    end
                    if (i_out_data.zero_total_weight !== want.zero_total_weight) begin
                        $error("zero_total_weight: expected %0b, got %0b",
                               want.zero_total_weight, i_out_data.zero_total_weight);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                // total wraps modulo its width; a zero total leaves the mean alone
                weight_total = weight_total + TOTAL_W'(i_in_data.component_weight);
                if (weight_total != '0) begin
                    mean_acc = next_mean(mean_acc, i_in_data.component_value,
                                         i_in_data.component_weight, weight_total);
                end
                if (i_in_data.last_component) begin
                    want.weighted_mean     = mean_acc;
                    want.zero_total_weight = (weight_total == '0);
                    if (want.zero_total_weight) begin
                        empty_runs++;
                    end
                    expected_means.push_back(want);
                    mean_acc     = '0;
                    weight_total = '0;
                end
            end
        end
        o_pending <= expected_means.size();
    end

endmodule

### dv/testbench.sv
// Testbench top for the running weighted mean unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import rwm_pkg::*;

    localparam int COMPONENT_TARGET = 625;
    localparam int HOLD_CYCLES      = 600;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
    localparam logic [WEIGHT_W-1:0]       WEIGHT_MAX = '1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    int fail_count;
    int pending;
    int means_checked;
    int empty_runs;
    int components_sent;
    int runs_sent;
    int hold_requests;
    bit in_idle_on;
    bit out_idle_on;

    running_weighted_mean_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rwm_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_means_checked (means_checked),
        .o_empty_runs    (empty_runs)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stall, or a long counted hold-off when asked for
    initial begin
        int holds_served;
        holds_served = 0;
        out_stall    = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= out_idle_on && ($urandom_range(99) < 34);
        end
    end

    task automatic send_component(input logic signed [VALUE_W-1:0] value,
                                  input logic [WEIGHT_W-1:0] weight, input logic last);
        t_in_item item;
        item.component_value  = value;
        item.component_weight = weight;
        item.last_component   = last;
        while (in_idle_on && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        components_sent++;
        if (last) begin
            runs_sent++;
        end
    endtask

    task automatic send_random_run(input int len);
        logic signed [VALUE_W-1:0] value;
        logic [WEIGHT_W-1:0]       weight;
        bit                        weightless;
        weightless = ($urandom_range(11) == 0);
        for (int n = 0; n < len; n++) begin
            case ($urandom_range(9))
                0:       value = VALUE_MAX;
                1:       value = VALUE_MIN;
                2, 3:    value = $urandom_range(200) - 100;
                default: value = $urandom;
            endcase
            case ($urandom_range(7))
                0:       weight = '0;
                1:       weight = WEIGHT_MAX;
                2:       weight = WEIGHT_W'($urandom_range(3));
                default: weight = WEIGHT_W'($urandom);
            endcase
            if (weightless) begin
                weight = '0;
            end
            send_component(value, weight, n == len - 1);
        end
    endtask

    // pending is registered in the checker, so let it update before reading it
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin
        int  run_len;
        bit  paused;
        bit  held;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        in_idle_on      = 1'b1;
        out_idle_on     = 1'b1;
        hold_requests   = 0;
        components_sent = 0;
        runs_sent       = 0;
        paused          = 1'b0;
        held            = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-component runs at the value extremes
        send_component(VALUE_MAX, WEIGHT_MAX, 1'b1);
        send_component(VALUE_MIN, 16'd1, 1'b1);
        // all weights zero: flag set, mean stays 0
        send_component(32'sd5, '0, 1'b0);
        send_component(-32'sd7, '0, 1'b1);
        send_component('0, '0, 1'b1);
        // zero weight in mid-run leaves the mean untouched
        send_component(32'sd100, 16'd3, 1'b0);
        send_component(-32'sd50, '0, 1'b0);
        send_component(32'sd20, 16'd1, 1'b1);
        // truncation toward zero on negative steps, from a mean of 0 and from a mean of 7
        send_component('0, 16'd1, 1'b0);
        send_component(-32'sd7, 16'd2, 1'b1);
        send_component(32'sd7, 16'd2, 1'b0);
        send_component('0, 16'd1, 1'b1);
        // widest difference in both directions
        send_component(VALUE_MAX, 16'd1, 1'b0);
        send_component(VALUE_MIN, 16'd1, 1'b1);
        send_component(VALUE_MIN, WEIGHT_MAX, 1'b0);
        send_component(VALUE_MAX, WEIGHT_MAX, 1'b0);
        send_component(VALUE_MAX, WEIGHT_MAX, 1'b1);
        send_component(-32'sd1, 16'h8000, 1'b0);
        send_component(32'sd1, 16'h7fff, 1'b1);

        while (components_sent < COMPONENT_TARGET) begin
            // a quiet stretch with neither side idling
            in_idle_on = !(components_sent >= 200 && components_sent < 300);
            out_idle_on <= !(components_sent >= 200 && components_sent < 300);
            if (!paused && components_sent >= 350) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                wait_drained();
            end
            if (!held && components_sent >= 450) begin
                held = 1'b1;
                hold_requests <= hold_requests + 1;
            end
            run_len = ($urandom_range(15) == 0) ? $urandom_range(30, 10) : $urandom_range(6, 1);
            send_random_run(run_len);
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (60) @(posedge clk);
        $display("Drove %0d components in %0d runs; compared %0d means,",
                 components_sent, runs_sent, means_checked);
        $display("%0d of them with zero total weight.", empty_runs);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
src/rwm_pkg.sv
src/running_weighted_mean_unit.sv
dv/rwm_checker.sv
dv/testbench.sv
